FILE: hdl/lru_page_replacement_core_macros.svh
// Assertion macros shared by the checkers of the LRU page replacement core.
// Depends on nothing; included by hdl/lrupr_checker.sv.
`ifndef LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lrupr_pkg.sv
// Package of the LRU page replacement core: field widths, parameter defaults,
// register map. Depends on nothing.
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int AGE_BITS_DEF  = 16;

    localparam int PAGE_NUMBER_W  = 16;
    localparam int FRAME_SLOT_W   = 4;
    localparam int EVICTED_PAGE_W = 16;
    localparam int FAULT_COUNT_W  = 32;

    localparam int FRAMES_IN_USE_W = 5;
    localparam logic [FRAMES_IN_USE_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [PADDR_W-3:0] {
        REG_FRAMES_IN_USE = 1'b0
    } t_reg_idx;

endpackage

FILE: hdl/lrupr_if.sv
// Valid/ready channel interfaces of the LRU page replacement core.
// Depends on lrupr_pkg for the payload widths.
`timescale 1ns / 1ps

interface lrupr_req_if;
    logic                                valid;
    logic                                ready;
    logic [lrupr_pkg::PAGE_NUMBER_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic [lrupr_pkg::FRAME_SLOT_W-1:0]   frame_slot;
    logic                                 evicted_valid;
    logic [lrupr_pkg::EVICTED_PAGE_W-1:0] evicted_page;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0]  fault_count;

    modport source (output valid, output hit, output frame_slot, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

FILE: hdl/lru_page_replacement_core.sv
// LRU page replacement core with per-frame age counters.
// Depends on lrupr_pkg, lrupr_if.sv and lrupr_ram.
//
// Usage: each transfer on i_req carries one referenced page number. For each
// one, a single result transfer on o_rsp reports hit or fault, the frame that
// holds the page, the evicted page on a replacing miss and the saturating
// fault count. The APB port holds frames_in_use at byte address 0; the user
// must write it only while the core is idle, which the core does not enforce,
// and reads return the stored value. The number of frames in use is clamped
// to 1..FRAMES. The frame table lives in one RAM that is read once per frame
// in use, one frame per cycle, while aged entries are written back in the
// cycle after each read; a final write places the page. The next item is
// accepted in the cycle after the result is loaded, so the core does not take
// a new item before it is through with the last one.
// Reset empties all frames, restores descending ages and clears the fault
// count at once through per-frame valid bits, with no clearing pass.
// A result that the receiver stalls is held in the output register; the core
// still takes the next item and holds its result until the output is free.
`timescale 1ns / 1ps

module lru_page_replacement_core #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int AGE_BITS  = lrupr_pkg::AGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lrupr_req_if.sink                       i_req,
    lrupr_rsp_if.source                     o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lrupr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lrupr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lrupr_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int CFGW = lrupr_pkg::FRAMES_IN_USE_W;

    typedef struct packed {
        logic                 filled;
        logic [PAGE_BITS-1:0] page;
        logic [AGE_BITS-1:0]  age;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state                 r_state;
    logic [CFGW-1:0]        r_cfg;
    logic [PAGE_BITS-1:0]   r_page;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          r_cnt;
    logic                   r_pv;
    logic [AW-1:0]          r_pa;
    logic                   r_hit;
    logic [AW-1:0]          r_hit_slot;
    logic [AGE_BITS-1:0]    r_best_age;
    logic [AW-1:0]          r_best_slot;
    logic                   r_best_filled;
    logic [PAGE_BITS-1:0]   r_best_page;
    logic [FRAMES-1:0]      r_touched;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0]  r_faults;
    logic                                 r_o_valid;
    logic                                 r_o_hit;
    logic [lrupr_pkg::FRAME_SLOT_W-1:0]   r_o_slot;
    logic                                 r_o_ev_valid;
    logic [lrupr_pkg::EVICTED_PAGE_W-1:0] r_o_ev_page;

    logic [CW-1:0]          n_n;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0] n_faults;
    logic [EW-1:0]          ram_rdata;
    t_entry                 rd_ent;
    logic [AGE_BITS-1:0]    aged;
    logic                   match;
    logic                   older;
    logic                   fin_go;
    logic [AW-1:0]          slot;
    logic                   ev_valid;
    logic                   cfg_wr;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    t_entry                 ram_wdata;

    always_comb begin
        if (r_cfg == '0) begin
            n_n = CW'(1);
        end else if (32'(r_cfg) > 32'(FRAMES)) begin
            n_n = CW'(FRAMES);
        end else begin
            n_n = CW'(r_cfg);
        end
    end

    always_comb begin
        if (r_touched[r_pa]) begin
            rd_ent = t_entry'(ram_rdata);
        end else begin
            rd_ent.filled = 1'b0;
            rd_ent.page   = '0;
            rd_ent.age    = AGE_BITS'(FRAMES - 1) - AGE_BITS'(r_pa);
        end
    end

    assign aged     = (rd_ent.age == '1) ? rd_ent.age : rd_ent.age + 1'b1;
    assign match    = rd_ent.filled && (rd_ent.page == r_page);
    assign older    = (r_pa == '0) || (r_best_age < rd_ent.age);
    assign fin_go   = (r_state == S_FIN) && (!r_o_valid || o_rsp.ready);
    assign slot     = r_hit ? r_hit_slot : r_best_slot;
    assign ev_valid = !r_hit && r_best_filled;
    assign n_faults = (r_hit || r_faults == '1) ? r_faults : r_faults + 1'b1;
    assign cfg_wr   = psel && penable && pwrite &&
                      (paddr[lrupr_pkg::PADDR_W-1:2] == lrupr_pkg::REG_FRAMES_IN_USE);

    always_comb begin
        ram_we    = r_pv || fin_go;
        ram_waddr = r_pv ? r_pa : slot;
        if (r_pv) begin
            ram_wdata.filled = rd_ent.filled;
            ram_wdata.page   = rd_ent.page;
            ram_wdata.age    = aged;
        end else begin
            ram_wdata.filled = 1'b1;
            ram_wdata.page   = r_page;
            ram_wdata.age    = '0;
        end
    end

    lrupr_ram #(
        .WIDTH (EW),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= lrupr_pkg::FRAMES_IN_USE_RESET;
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_touched <= '0;
            r_faults  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cfg <= pwdata[CFGW-1:0];
            end
            if (o_rsp.ready && !fin_go) begin
                r_o_valid <= 1'b0;
            end
            r_pv <= (r_state == S_SCAN);
            r_pa <= r_cnt[AW-1:0];
            if (r_pv) begin
                r_touched[r_pa] <= 1'b1;
                if (match && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_pa;
                end
                if (older) begin
                    r_best_age    <= rd_ent.age;
                    r_best_slot   <= r_pa;
                    r_best_filled <= rd_ent.filled;
                    r_best_page   <= rd_ent.page;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_page  <= PAGE_BITS'(i_req.page_number);
                        r_n     <= n_n;
                        r_cnt   <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_touched[slot] <= 1'b1;
                        r_faults        <= n_faults;
                        r_o_valid       <= 1'b1;
                        r_o_hit         <= r_hit;
                        r_o_slot        <= lrupr_pkg::FRAME_SLOT_W'(slot);
                        r_o_ev_valid    <= ev_valid;
                        r_o_ev_page     <= ev_valid ?
                                           lrupr_pkg::EVICTED_PAGE_W'(r_best_page) : '0;
                        r_state         <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE) && i_rst_n;
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.hit           = r_o_hit;
    assign o_rsp.frame_slot    = r_o_slot;
    assign o_rsp.evicted_valid = r_o_ev_valid;
    assign o_rsp.evicted_page  = r_o_ev_page;
    assign o_rsp.fault_count   = r_faults;

    assign pready = 1'b1;
    assign prdata = (paddr[lrupr_pkg::PADDR_W-1:2] == lrupr_pkg::REG_FRAMES_IN_USE) ?
                    lrupr_pkg::PDATA_W'(r_cfg) : '0;

endmodule

FILE: hdl/lrupr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module lrupr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lrupr_checker.sv
// Port-level checker of the LRU page replacement core and its bind statement.
// Depends on lrupr_pkg and lru_page_replacement_core_macros.svh.
`timescale 1ns / 1ps
`include "lru_page_replacement_core_macros.svh"

module lrupr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_req_valid,
    input logic                                 i_req_ready,
    input logic                                 i_rsp_valid,
    input logic                                 i_rsp_ready,
    input logic                                 i_rsp_hit,
    input logic [lrupr_pkg::FRAME_SLOT_W-1:0]   i_rsp_frame_slot,
    input logic                                 i_rsp_evicted_valid,
    input logic [lrupr_pkg::EVICTED_PAGE_W-1:0] i_rsp_evicted_page,
    input logic [lrupr_pkg::FAULT_COUNT_W-1:0]  i_rsp_fault_count
);

    logic req_xfer;

    assign req_xfer = i_req_valid && i_req_ready;

    `LRUPR_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, req_xfer, !i_req_ready, "input accepted while an item is in work")
    `LRUPR_ASSERT_NOW(a_min_latency, i_clk, i_rst_n, $rose(i_rsp_valid), !$past(req_xfer) && !$past(req_xfer, 2), "result appeared too soon after a transfer")
    `LRUPR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "stalled result dropped")
    `LRUPR_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_hit) && $stable(i_rsp_frame_slot) && $stable(i_rsp_evicted_valid) && $stable(i_rsp_evicted_page) && $stable(i_rsp_fault_count), "stalled result changed")

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_hit           (o_rsp.hit),
    .i_rsp_frame_slot    (o_rsp.frame_slot),
    .i_rsp_evicted_valid (o_rsp.evicted_valid),
    .i_rsp_evicted_page  (o_rsp.evicted_page),
    .i_rsp_fault_count   (o_rsp.fault_count)
);
